// File: hdl/gna_pkg.sv
// Gaussian noise adder: shared types, constants and helper functions.
// No dependencies; every other file of the block but gna_ram uses this package.
package gna_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int CORDIC_STEPS_DEF    = 20;

  // twister geometry
  localparam int TW_N = 624;
  localparam int TW_M = 397;

  localparam logic [31:0] SEED_MULT       = 32'd1812433253;
  localparam logic [31:0] MATRIX_A        = 32'h9908B0DF;
  localparam logic [31:0] SEED_RESET      = 32'd5489;
  localparam logic [31:0] U1_FLOOR_WORD   = 32'd430;
  localparam logic [31:0] TWO_LN2_Q30     = 32'd1488522236;
  localparam logic [31:0] HALF_PI_Q30     = 32'd1686629713;
  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

  localparam int NORMAL_W = 20;

  // configuration register map
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 4'd1;

  typedef struct packed {
    logic               first_point;
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] z_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;
  } out_item_t;

  typedef logic signed [NORMAL_W-1:0] normal_t;

  // command to the generator, one-cycle pulse
  typedef struct packed {
    logic seed;
    logic draw;
  } tw_req_t;

  // arctangent of 2^-i, Q.30, truncated
  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0:  v = 34'sh03243F6A8;
      5'd1:  v = 34'sh01DAC6705;
      5'd2:  v = 34'sh00FADBAFC;
      5'd3:  v = 34'sh007F56EA6;
      5'd4:  v = 34'sh003FEAB76;
      5'd5:  v = 34'sh001FFD55B;
      5'd6:  v = 34'sh000FFFAAA;
      5'd7:  v = 34'sh0007FFF55;
      5'd8:  v = 34'sh0003FFFEA;
      5'd9:  v = 34'sh0001FFFFD;
      5'd10: v = 34'sh0000FFFFF;
      5'd11: v = 34'sh00007FFFF;
      5'd12: v = 34'sh00003FFFF;
      5'd13: v = 34'sh00001FFFF;
      5'd14: v = 34'sh00000FFFF;
      5'd15: v = 34'sh000007FFF;
      5'd16: v = 34'sh000003FFF;
      5'd17: v = 34'sh000001FFF;
      5'd18: v = 34'sh000000FFF;
      5'd19: v = 34'sh0000007FF;
      5'd20: v = 34'sh0000003FF;
      5'd21: v = 34'sh0000001FF;
      5'd22: v = 34'sh0000000FF;
      5'd23: v = 34'sh00000007F;
      5'd24: v = 34'sh00000003F;
      5'd25: v = 34'sh00000001F;
      5'd26: v = 34'sh00000000F;
      5'd27: v = 34'sh000000008;
      5'd28: v = 34'sh000000004;
      5'd29: v = 34'sh000000002;
      5'd30: v = 34'sh000000001;
      default: v = 34'sh000000000;
    endcase
    return v;
  endfunction

  // output tempering of the twister
  function automatic logic [31:0] temper(input logic [31:0] y);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    a = y ^ (y >> 11);
    b = a ^ ((a << 7) & 32'h9D2C5680);
    c = b ^ ((b << 15) & 32'hEFC60000);
    return c ^ (c >> 18);
  endfunction

endpackage

// File: hdl/gaussian_noise_adder.sv
// Gaussian noise adder top level: config registers, point sequencer, output register.
// Depends on gna_pkg, gna_twister (uniform words) and gna_bm (normal pairs).
//
//   channel  ports                                   direction  moves
//   in       in_valid, in_ready, in_data             sink       one point per transaction
//   out      out_valid, out_ready, out_data          source     one noisy point
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data sink     one register write
//
// With the sigma register zero a point passes through. Otherwise each coordinate
// uses a stored spare normal, or a fresh pair made by two draws, normalization shifts,
// log, 20 root steps and CORDIC. A first point adds seeding of the state words;
// the first draw after a seed and every 624th draw after it add regeneration, slowed
// by the single read port of the state RAM. Reset sets control, sigma, seed and spare.
// A finished point waits in the output register while the next one is taken.
module gaussian_noise_adder #(
  parameter int COORD_FRAC_BITS = gna_pkg::COORD_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = gna_pkg::CORDIC_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  gna_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output gna_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gna_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);
  import gna_pkg::*;

  // right shift that takes sigma*normal (Q.32) to the coordinate format
  localparam int SH = 32 - COORD_FRAC_BITS;

  localparam logic [3:0] T_IDLE     = 4'd0;
  localparam logic [3:0] T_SEED_REQ = 4'd1;
  localparam logic [3:0] T_SEED_WT  = 4'd2;
  localparam logic [3:0] T_COORD    = 4'd3;
  localparam logic [3:0] T_D1_REQ   = 4'd4;
  localparam logic [3:0] T_D1_WT    = 4'd5;
  localparam logic [3:0] T_D2_REQ   = 4'd6;
  localparam logic [3:0] T_D2_WT    = 4'd7;
  localparam logic [3:0] T_BM_WT    = 4'd8;
  localparam logic [3:0] T_MUL      = 4'd9;
  localparam logic [3:0] T_ADD      = 4'd10;
  localparam logic [3:0] T_DONE     = 4'd11;

  logic [3:0]             state_r, state_nxt;
  logic [23:0]            sigma_r, sigma_nxt;
  logic [31:0]            seed_r, seed_nxt;
  logic [2:0][31:0]       crd_r, crd_nxt;
  logic [2:0][31:0]       res_r, res_nxt;
  logic [1:0]             cidx_r, cidx_nxt;
  logic                   spv_r, spv_nxt;
  normal_t                spare_r, spare_nxt;
  normal_t                normal_r, normal_nxt;
  logic [31:0]            w1_r, w1_nxt;
  logic signed [44:0]     prod_r, prod_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  tw_req_t                tw_req;
  logic                   tw_done;
  logic [31:0]            tw_word;
  logic                   bm_start, bm_done;
  normal_t                bm_c, bm_s;

  logic signed [45:0]     rnd;
  logic signed [45:0]     noise;
  logic signed [46:0]     sum;
  logic [31:0]            sat;

  gna_twister u_tw (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (tw_req),
    .seed (seed_r),
    .done (tw_done),
    .word (tw_word)
  );

  gna_bm #(.CORDIC_STEPS(CORDIC_STEPS)) u_bm (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (bm_start),
    .w1      (w1_r),
    .w2      (tw_word),
    .done    (bm_done),
    .normal_c(bm_c),
    .normal_s(bm_s)
  );

  assign in_ready  = (state_r == T_IDLE);
  assign cfg_ready = 1'b1;
  assign bm_start  = (state_r == T_D2_WT) && tw_done;

  // round to nearest, ties up, then saturate the sum
  assign rnd   = {prod_r[44], prod_r} + (46'sd1 <<< (SH - 1));
  assign noise = rnd >>> SH;
  assign sum   = {{15{crd_r[cidx_r][31]}}, crd_r[cidx_r]} + {noise[45], noise};
  assign sat   = (sum > 47'sd2147483647)  ? 32'h7FFFFFFF :
                 (sum < -47'sd2147483648) ? 32'h80000000 : sum[31:0];

  always_comb begin
    sigma_nxt = sigma_r;
    seed_nxt  = seed_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SIGMA: sigma_nxt = cfg_data[23:0];
        CFG_SEED:  seed_nxt  = cfg_data;
        default:   sigma_nxt = sigma_r;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    crd_nxt       = crd_r;
    res_nxt       = res_r;
    cidx_nxt      = cidx_r;
    spv_nxt       = spv_r;
    spare_nxt     = spare_r;
    normal_nxt    = normal_r;
    w1_nxt        = w1_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    tw_req        = '0;
    case (state_r)
      T_IDLE: begin
        if (in_valid) begin
          crd_nxt  = {in_data.z_in, in_data.y_in, in_data.x_in};
          cidx_nxt = '0;
          if (in_data.first_point) begin
            spv_nxt   = 1'b0;
            spare_nxt = '0;
            state_nxt = T_SEED_REQ;
          end else begin
            state_nxt = T_COORD;
          end
        end
      end
      T_SEED_REQ: begin
        tw_req.seed = 1'b1;
        state_nxt   = T_SEED_WT;
      end
      T_SEED_WT: begin
        if (tw_done) begin
          state_nxt = T_COORD;
        end
      end
      T_COORD: begin
        if (sigma_r == '0) begin
          res_nxt   = crd_r;
          state_nxt = T_DONE;
        end else if (spv_r) begin
          normal_nxt = spare_r;
          spv_nxt    = 1'b0;
          state_nxt  = T_MUL;
        end else begin
          state_nxt = T_D1_REQ;
        end
      end
      T_D1_REQ: begin
        tw_req.draw = 1'b1;
        state_nxt   = T_D1_WT;
      end
      T_D1_WT: begin
        if (tw_done) begin
          w1_nxt    = tw_word;
          state_nxt = T_D2_REQ;
        end
      end
      T_D2_REQ: begin
        tw_req.draw = 1'b1;
        state_nxt   = T_D2_WT;
      end
      T_D2_WT: begin
        // second word goes straight into the Box-Muller unit
        if (tw_done) begin
          state_nxt = T_BM_WT;
        end
      end
      T_BM_WT: begin
        if (bm_done) begin
          normal_nxt = bm_c;
          spare_nxt  = bm_s;
          spv_nxt    = 1'b1;
          state_nxt  = T_MUL;
        end
      end
      T_MUL: begin
        prod_nxt  = $signed({1'b0, sigma_r}) * normal_r;
        state_nxt = T_ADD;
      end
      T_ADD: begin
        res_nxt[cidx_r] = sat;
        if (cidx_r == 2'd2) begin
          state_nxt = T_DONE;
        end else begin
          cidx_nxt  = cidx_r + 2'd1;
          state_nxt = T_COORD;
        end
      end
      T_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {res_r[0], res_r[1], res_r[2]};
          state_nxt     = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      sigma_r     <= '0;
      seed_r      <= SEED_RESET;
      spv_r       <= 1'b0;
      spare_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sigma_r     <= sigma_nxt;
      seed_r      <= seed_nxt;
      spv_r       <= spv_nxt;
      spare_r     <= spare_nxt;
      out_valid_r <= out_valid_nxt;
    end
    crd_r      <= crd_nxt;
    res_r      <= res_nxt;
    cidx_r     <= cidx_nxt;
    normal_r   <= normal_nxt;
    w1_r       <= w1_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/gna_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gna_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/gna_twister.sv
// Twister generator: seeding, block regeneration and tempered draws.
// Depends on gna_pkg and gna_ram (state words).
module gna_twister (
  input  logic             clk,
  input  logic             rst_n,
  input  gna_pkg::tw_req_t req,
  input  logic [31:0]      seed,
  output logic             done,
  output logic [31:0]      word
);
  import gna_pkg::*;

  localparam int AW = $clog2(TW_N);

  localparam logic [3:0] TS_IDLE     = 4'd0;
  localparam logic [3:0] TS_SEED_MUL = 4'd1;
  localparam logic [3:0] TS_SEED_WR  = 4'd2;
  localparam logic [3:0] TS_RG_A     = 4'd3;
  localparam logic [3:0] TS_RG_B     = 4'd4;
  localparam logic [3:0] TS_RG_C     = 4'd5;
  localparam logic [3:0] TS_RG_D     = 4'd6;
  localparam logic [3:0] TS_DR_A     = 4'd7;
  localparam logic [3:0] TS_DR_B     = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [31:0]   prev_r, prev_nxt;
  logic [31:0]   prod_r, prod_nxt;
  logic [31:0]   a_r, a_nxt;
  logic [31:0]   b_r, b_nxt;
  logic [31:0]   word_r, word_nxt;
  logic          done_r, done_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;
  logic [AW-1:0] k1, km;
  logic [AW:0]   km_sum;
  logic [31:0]   seed_val, mix, twist;

  gna_ram #(.WIDTH(32), .DEPTH(TW_N)) u_words (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // neighbor indices, wrapped
  assign k1     = (cnt_r == AW'(TW_N - 1)) ? '0 : cnt_r + AW'(1);
  assign km_sum = {1'b0, cnt_r} + (AW + 1)'(TW_M);
  assign km     = (km_sum >= (AW + 1)'(TW_N)) ? AW'(km_sum - (AW + 1)'(TW_N)) : km_sum[AW-1:0];

  assign seed_val = prod_r + {{(32 - AW){1'b0}}, cnt_r};
  assign mix      = {a_r[31], b_r[30:0]};
  assign twist    = rdata ^ (mix >> 1) ^ (mix[0] ? MATRIX_A : 32'd0);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    prev_nxt  = prev_r;
    prod_nxt  = prod_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    word_nxt  = word_r;
    done_nxt  = 1'b0;
    we        = 1'b0;
    waddr     = cnt_r;
    wdata     = seed_val;
    raddr     = cnt_r;
    case (state_r)
      TS_IDLE: begin
        if (req.seed) begin
          we        = 1'b1;
          waddr     = '0;
          wdata     = seed;
          prev_nxt  = seed;
          cnt_nxt   = AW'(1);
          state_nxt = TS_SEED_MUL;
        end else if (req.draw) begin
          if (pos_r >= AW'(TW_N)) begin
            cnt_nxt   = '0;
            state_nxt = TS_RG_A;
          end else begin
            state_nxt = TS_DR_A;
          end
        end
      end
      TS_SEED_MUL: begin
        prod_nxt  = SEED_MULT * (prev_r ^ (prev_r >> 30));
        state_nxt = TS_SEED_WR;
      end
      TS_SEED_WR: begin
        we       = 1'b1;
        prev_nxt = seed_val;
        if (cnt_r == AW'(TW_N - 1)) begin
          pos_nxt   = AW'(TW_N);
          done_nxt  = 1'b1;
          state_nxt = TS_IDLE;
        end else begin
          cnt_nxt   = cnt_r + AW'(1);
          state_nxt = TS_SEED_MUL;
        end
      end
      TS_RG_A: begin
        state_nxt = TS_RG_B;
      end
      TS_RG_B: begin
        a_nxt     = rdata;
        raddr     = k1;
        state_nxt = TS_RG_C;
      end
      TS_RG_C: begin
        b_nxt     = rdata;
        raddr     = km;
        state_nxt = TS_RG_D;
      end
      TS_RG_D: begin
        we    = 1'b1;
        wdata = twist;
        if (cnt_r == AW'(TW_N - 1)) begin
          pos_nxt   = '0;
          state_nxt = TS_DR_A;
        end else begin
          cnt_nxt   = cnt_r + AW'(1);
          state_nxt = TS_RG_A;
        end
      end
      TS_DR_A: begin
        raddr     = pos_r;
        state_nxt = TS_DR_B;
      end
      TS_DR_B: begin
        word_nxt  = temper(rdata);
        pos_nxt   = pos_r + AW'(1);
        done_nxt  = 1'b1;
        state_nxt = TS_IDLE;
      end
      default: begin
        state_nxt = TS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TS_IDLE;
      pos_r   <= AW'(TW_N);
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      done_r  <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    prev_r <= prev_nxt;
    prod_r <= prod_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    word_r <= word_nxt;
  end

  assign done = done_r;
  assign word = word_r;

endmodule

// File: hdl/gna_bm.sv
// Box-Muller unit: log by squaring, root by bit recurrence, CORDIC sin/cos,
// all multiplies on one shared multiplier. Depends on gna_pkg.
module gna_bm #(
  parameter int CORDIC_STEPS = gna_pkg::CORDIC_STEPS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [31:0]      w1,
  input  logic [31:0]      w2,
  output logic             done,
  output gna_pkg::normal_t normal_c,
  output gna_pkg::normal_t normal_s
);
  import gna_pkg::*;

  localparam int IW = $clog2(CORDIC_STEPS);

  localparam logic [3:0] B_IDLE   = 4'd0;
  localparam logic [3:0] B_NORM   = 4'd1;
  localparam logic [3:0] B_LOG    = 4'd2;
  localparam logic [3:0] B_SCALE  = 4'd3;
  localparam logic [3:0] B_SQRT   = 4'd4;
  localparam logic [3:0] B_ANGLE  = 4'd5;
  localparam logic [3:0] B_CORDIC = 4'd6;
  localparam logic [3:0] B_MAP    = 4'd7;
  localparam logic [3:0] B_MULC   = 4'd8;
  localparam logic [3:0] B_MULS   = 4'd9;

  logic [3:0]         state_r, state_nxt;
  logic [31:0]        m_r, m_nxt;
  logic [4:0]         lz_r, lz_nxt;
  logic [31:0]        bits_r, bits_nxt;
  logic [IW-1:0]      step_r, step_nxt;
  logic [38:0]        rem_r, rem_nxt;
  logic [39:0]        root_r, root_nxt;
  logic [4:0]         sq_r, sq_nxt;
  logic [31:0]        w2_r, w2_nxt;
  logic signed [33:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic signed [33:0] cs_r, cs_nxt, sn_r, sn_nxt;
  normal_t            nc_r, nc_nxt, ns_r, ns_nxt;
  logic               done_r, done_nxt;

  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  logic [32:0]        mm;
  logic [36:0]        t;
  logic [39:0]        sbit, trial;
  logic signed [33:0] dx, dy, ang;

  function automatic normal_t clamp_n(input logic signed [67:0] p);
    logic signed [67:0] v;
    v = p >>> 30;
    if (v > 68'sd524287) begin
      return normal_t'(20'sh7FFFF);
    end else if (v < -68'sd524288) begin
      return normal_t'(20'sh80000);
    end
    return v[NORMAL_W-1:0];
  endfunction

  // shared multiplier
  assign prod = ma * mb;

  assign mm    = prod[63:31];
  assign t     = {lz_r + 5'd1, 32'd0} - {5'd0, bits_r << (32 - CORDIC_STEPS)};
  assign sbit  = 40'd1 << {sq_r, 1'b0};
  assign trial = root_r + sbit;
  assign dx    = y_r >>> step_r;
  assign dy    = x_r >>> step_r;
  assign ang   = atan_q30(5'(step_r));

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      B_LOG: begin
        ma = $signed({2'b00, m_r});
        mb = $signed({2'b00, m_r});
      end
      B_SCALE: begin
        ma = $signed({5'd0, t[36:8]});
        mb = $signed({2'b00, TWO_LN2_Q30});
      end
      B_ANGLE: begin
        ma = $signed({4'd0, w2_r[29:0]});
        mb = $signed({2'b00, HALF_PI_Q30});
      end
      B_MULC: begin
        ma = $signed({14'd0, root_r[19:0]});
        mb = cs_r;
      end
      B_MULS: begin
        ma = $signed({14'd0, root_r[19:0]});
        mb = sn_r;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    m_nxt     = m_r;
    lz_nxt    = lz_r;
    bits_nxt  = bits_r;
    step_nxt  = step_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    sq_nxt    = sq_r;
    w2_nxt    = w2_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    cs_nxt    = cs_r;
    sn_nxt    = sn_r;
    nc_nxt    = nc_r;
    ns_nxt    = ns_r;
    done_nxt  = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (start) begin
          m_nxt     = (w1 < U1_FLOOR_WORD) ? U1_FLOOR_WORD : w1;
          w2_nxt    = w2;
          lz_nxt    = '0;
          state_nxt = B_NORM;
        end
      end
      B_NORM: begin
        // one bit of normalization per cycle
        if (m_r[31]) begin
          bits_nxt  = '0;
          step_nxt  = '0;
          state_nxt = B_LOG;
        end else begin
          m_nxt  = m_r << 1;
          lz_nxt = lz_r + 5'd1;
        end
      end
      B_LOG: begin
        if (mm[32]) begin
          m_nxt    = mm[32:1];
          bits_nxt = {bits_r[30:0], 1'b1};
        end else begin
          m_nxt    = mm[31:0];
          bits_nxt = {bits_r[30:0], 1'b0};
        end
        if (step_r == IW'(CORDIC_STEPS - 1)) begin
          state_nxt = B_SCALE;
        end else begin
          step_nxt = step_r + IW'(1);
        end
      end
      B_SCALE: begin
        rem_nxt   = {1'b0, prod[59:30], 8'd0};
        root_nxt  = '0;
        sq_nxt    = 5'd19;
        state_nxt = B_SQRT;
      end
      B_SQRT: begin
        if ({1'b0, rem_r} >= trial) begin
          rem_nxt  = rem_r - trial[38:0];
          root_nxt = (root_r >> 1) + sbit;
        end else begin
          root_nxt = root_r >> 1;
        end
        if (sq_r == 5'd0) begin
          state_nxt = B_ANGLE;
        end else begin
          sq_nxt = sq_r - 5'd1;
        end
      end
      B_ANGLE: begin
        z_nxt     = $signed({3'b000, prod[60:30]});
        x_nxt     = $signed({2'b00, CORDIC_GAIN_Q30});
        y_nxt     = '0;
        step_nxt  = '0;
        state_nxt = B_CORDIC;
      end
      B_CORDIC: begin
        if (!z_r[33]) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - ang;
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + ang;
        end
        if (step_r == IW'(CORDIC_STEPS - 1)) begin
          state_nxt = B_MAP;
        end else begin
          step_nxt = step_r + IW'(1);
        end
      end
      B_MAP: begin
        // quadrant from the top two bits of the angle word
        case (w2_r[31:30])
          2'd0: begin
            cs_nxt = x_r;
            sn_nxt = y_r;
          end
          2'd1: begin
            cs_nxt = -y_r;
            sn_nxt = x_r;
          end
          2'd2: begin
            cs_nxt = -x_r;
            sn_nxt = -y_r;
          end
          default: begin
            cs_nxt = y_r;
            sn_nxt = -x_r;
          end
        endcase
        state_nxt = B_MULC;
      end
      B_MULC: begin
        nc_nxt    = clamp_n(prod);
        state_nxt = B_MULS;
      end
      B_MULS: begin
        ns_nxt    = clamp_n(prod);
        done_nxt  = 1'b1;
        state_nxt = B_IDLE;
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    m_r    <= m_nxt;
    lz_r   <= lz_nxt;
    bits_r <= bits_nxt;
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    sq_r   <= sq_nxt;
    w2_r   <= w2_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    cs_r   <= cs_nxt;
    sn_r   <= sn_nxt;
    nc_r   <= nc_nxt;
    ns_r   <= ns_nxt;
  end

  assign done     = done_r;
  assign normal_c = nc_r;
  assign normal_s = ns_r;

endmodule

// File: hdl/gna_checker.sv
// Port-level checks for the Gaussian noise adder, bound to the top level.
// Depends on gna_pkg and gaussian_noise_adder.
module gna_port_checks (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input gna_pkg::out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("out transaction changed while stalled");

  // a point keeps the block busy for at least the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // a result never appears in the cycle right after an input transaction
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result too early");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set out of reset");

endmodule

bind gaussian_noise_adder gna_port_checks u_gna_checker (.*);

// File: dv/gna_checker.sv
// Scoreboard for the Gaussian noise adder: watches the in, out and cfg channels,
// predicts each noisy point and compares it field by field. Depends on gna_pkg.
`timescale 1ns / 1ps
module gna_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  gna_pkg::in_item_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  gna_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [gna_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          end_check,
  output int                            fail_count,
  output int                            pending,
  output int                            points_checked
);
  import gna_pkg::*;

  localparam int FRAC  = COORD_FRAC_BITS_DEF;
  localparam int STEPS = CORDIC_STEPS_DEF;

  logic [31:0]        mt_words [TW_N];
  int                 mt_pos;
  bit                 spare_ok;
  logic signed [19:0] spare_val;
  logic [23:0]        sigma_reg;
  logic [31:0]        seed_reg;
  out_item_t          noisy_q [$];
  bit                 leftovers_done;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic void mt_reseed(input logic [31:0] s);
    logic [31:0] p;
    mt_words[0] = s;
    for (int i = 1; i < TW_N; i++) begin
      p = mt_words[i-1];
      mt_words[i] = SEED_MULT * (p ^ (p >> 30)) + i;
    end
    mt_pos = TW_N;
  endfunction

  function automatic logic [31:0] mt_next();
    logic [31:0] v;
    logic [31:0] w;
    if (mt_pos >= TW_N) begin
      for (int k = 0; k < TW_N; k++) begin
        v = (mt_words[k] & 32'h80000000) | (mt_words[(k+1) % TW_N] & 32'h7FFFFFFF);
        w = mt_words[(k+TW_M) % TW_N] ^ (v >> 1);
        if (v[0]) w ^= MATRIX_A;
        mt_words[k] = w;
      end
      mt_pos = 0;
    end
    w = mt_words[mt_pos];
    mt_pos++;
    return temper(w);
  endfunction

  // sqrt(-2 ln(w/2^32)) in Q.16
  function automatic longint unsigned bm_radius(input logic [31:0] w);
    int p;
    longint unsigned m, bits, t, s, root, bitv, rem;
    p = 31;
    while (!w[p]) p--;
    m = 64'(w) << (31 - p);
    bits = 0;
    for (int i = 0; i < STEPS; i++) begin
      m = (m * m) >> 31;
      bits <<= 1;
      if (m >= 64'h1_0000_0000) begin
        m >>= 1;
        bits |= 1;
      end
    end
    t = (64'(32 - p) << 32) - (bits << (32 - STEPS));
    s = (((t >> 8) * 64'(TWO_LN2_Q30)) >> 30) << 8;
    rem = s;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic signed [19:0] clamp_normal(input longint v);
    if (v > 524287) return 20'sh7FFFF;
    if (v < -524288) return 20'sh80000;
    return v[19:0];
  endfunction

  function automatic logic signed [19:0] gauss_draw();
    logic [31:0] w1, w2;
    longint r, x, y, z, dx, dy, cs, sn;
    if (spare_ok) begin
      spare_ok = 0;
      return spare_val;
    end
    w1 = mt_next();
    if (w1 < U1_FLOOR_WORD) w1 = U1_FLOOR_WORD;
    w2 = mt_next();
    r = longint'(bm_radius(w1));
    z = longint'(((64'(w2 & 32'h3FFFFFFF)) * 64'(HALF_PI_Q30)) >> 30);
    x = longint'(CORDIC_GAIN_Q30);
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_q30(i[4:0]));
      end else begin
        x += dx; y -= dy; z += longint'(atan_q30(i[4:0]));
      end
    end
    // quadrant from the top two bits: sign and swap
    case (w2[31:30])
      2'd0: begin cs = x;  sn = y;  end
      2'd1: begin cs = -y; sn = x;  end
      2'd2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
    spare_val = clamp_normal((r * sn) >>> 30);
    spare_ok = 1;
    return clamp_normal((r * cs) >>> 30);
  endfunction

  function automatic logic [31:0] add_noise(input logic signed [31:0] coord);
    longint prod, v;
    prod = longint'(sigma_reg) * longint'(gauss_draw());
    v = longint'(coord) + ((prod + (longint'(1) << (31 - FRAC))) >>> (32 - FRAC));
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic out_item_t predict_point(input in_item_t p);
    out_item_t o;
    if (p.first_point) begin
      mt_reseed(seed_reg);
      spare_ok = 0;
      spare_val = '0;
    end
    if (sigma_reg == 0) begin
      o.x_out = p.x_in;
      o.y_out = p.y_in;
      o.z_out = p.z_in;
    end else begin
      o.x_out = add_noise(p.x_in);
      o.y_out = add_noise(p.y_in);
      o.z_out = add_noise(p.z_in);
    end
    return o;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      foreach (mt_words[i]) mt_words[i] = '0;
      mt_pos = TW_N;
      spare_ok = 0;
      spare_val = '0;
      sigma_reg = '0;
      seed_reg = SEED_RESET;
      noisy_q.delete();
      fail_count = 0;
      points_checked = 0;
      leftovers_done = 0;
    end else begin
      // result side first: a point accepted this edge cannot leave this edge
      if (out_valid && out_ready) begin
        if (noisy_q.size() == 0) begin
          report_mismatch("unexpected result", out_data.x_out, '0);
        end else begin
          want = noisy_q.pop_front();
          if (out_data.x_out !== want.x_out) report_mismatch("x_out", out_data.x_out, want.x_out);
          if (out_data.y_out !== want.y_out) report_mismatch("y_out", out_data.y_out, want.y_out);
          if (out_data.z_out !== want.z_out) report_mismatch("z_out", out_data.z_out, want.z_out);
          points_checked++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SIGMA: sigma_reg = cfg_data[23:0];
          CFG_SEED:  seed_reg  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) noisy_q.insert(noisy_q.size(), predict_point(in_data));
      if (end_check && !leftovers_done) begin
        leftovers_done = 1;
        if (noisy_q.size() != 0)
          report_mismatch("results never delivered", noisy_q.size(), '0);
      end
    end
    pending = noisy_q.size();
  end

endmodule

// File: dv/tb_gaussian_noise_adder.sv
// Testbench top for gaussian_noise_adder: clock, reset, point and register stimulus,
// random idling on both channels, verdict. Depends on gna_pkg and gna_checker.
`timescale 1ns / 1ps
module tb_gaussian_noise_adder;
  import gna_pkg::*;

  // a few seeds, regenerations and one long stall fit far inside this
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd15;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_ready;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 0;
  out_item_t          out_data;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               end_check = 0;
  int                 fail_count, pending, points_checked;

  int  cycles = 0;
  bit  send_burst = 0;   // sender offers back to back
  bit  take_burst = 0;   // receiver never stalls
  bit  hold_req = 0;     // one long receiver stall
  int  cfg_writes = 0;
  int  phases = 0;

  always #1 clk = ~clk;

  gaussian_noise_adder u_top (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  gna_checker u_chk (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .end_check, .fail_count, .pending, .points_checked
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random stall per transaction, plus one long hold-off on request
  // while the sender keeps pushing, so the block backs up into in_ready.
  initial begin
    int gap;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 0;
        repeat (600) @(negedge clk);
        hold_req = 0;
      end else begin
        gap = take_burst ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
          out_ready <= 0;
          repeat (gap) @(negedge clk);
        end
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // called at a falling edge; returns at the falling edge after the transaction,
  // valid still high so a back-to-back point just overwrites the payload
  task automatic send_point(input in_item_t p);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // valid drops between writes, so writes are never back to back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
    cfg_writes++;
    @(negedge clk);
  endtask

  // drain: every result back, then a short settle before touching registers
  task automatic wait_drained();
    in_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 32'h7FFFFFFF - $urandom_range(0, 4096);
      1: return 32'h80000000 + $urandom_range(0, 4096);
      2: return $urandom_range(0, 8) - 4;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t mk_point(input bit fp, input logic [31:0] x,
                                        input logic [31:0] y, input logic [31:0] z);
    in_item_t p;
    p.first_point = fp;
    p.x_in = x;
    p.y_in = y;
    p.z_in = z;
    return p;
  endfunction

  task automatic random_phase(input logic [23:0] sigma, input logic [31:0] seed,
                              input int count, input bit with_hold);
    write_reg(CFG_SIGMA, {8'h0, sigma});
    write_reg(CFG_SEED, seed);
    phases++;
    send_burst = $urandom_range(0, 2) == 0;
    take_burst = $urandom_range(0, 2) == 0;
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == 10) hold_req = 1;
      // reseed at phase start, then now and then mid-stream
      send_point(mk_point(i == 0 || $urandom_range(0, 29) == 0,
                          pick_coord(), pick_coord(), pick_coord()));
      if (i == count / 2) begin
        send_burst = !send_burst;
        take_burst = !take_burst;
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed, sigma zero: points pass through, nothing is drawn;
    // a first point still reseeds with the reset seed.
    phases++;
    send_point(mk_point(0, 32'h7FFFFFFF, 32'h80000000, 32'h0));
    send_point(mk_point(1, 32'hFFFFFFFF, 32'h00000001, 32'h55555555));
    send_point(mk_point(0, 32'hAAAAAAAA, 32'h7FFFFFFF, 32'h80000000));
    wait_drained();

    // Directed, sigma one (Q8.16): out-of-map index must be ignored
    write_reg(CFG_UNUSED, 32'hFFFFFFFF);
    write_reg(CFG_SIGMA, 32'h0001_0000);
    phases++;
    send_point(mk_point(1, 32'h0, 32'h0, 32'h0));
    send_point(mk_point(0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF));
    send_point(mk_point(0, 32'h00000001, 32'h7FFFFFF0, 32'h80000010));
    send_point(mk_point(1, 32'h12345678, 32'h0, 32'h0));  // same seed again
    send_point(mk_point(0, 32'h0, 32'h0, 32'h0));
    wait_drained();

    // Directed, maximum sigma at the rails: saturation both ways
    write_reg(CFG_SIGMA, 32'h00FF_FFFF);
    write_reg(CFG_SEED, 32'hFFFFFFFF);
    phases++;
    send_point(mk_point(1, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
    for (int i = 0; i < 6; i++)
      send_point(mk_point(0, 32'h7FFFFFFF - i, 32'h80000000 + i, 32'h80000000));
    // sigma zero mid-stream keeps the spare for later
    wait_drained();
    write_reg(CFG_SIGMA, 32'h0);
    send_point(mk_point(0, 32'h1, 32'h2, 32'h3));
    wait_drained();
    write_reg(CFG_SIGMA, 32'h00FF_FFFF);
    send_point(mk_point(0, 32'h0, 32'h0, 32'h0));
    // zero seed, smallest sigma
    wait_drained();
    write_reg(CFG_SEED, 32'h0);
    write_reg(CFG_SIGMA, 32'h1);
    send_point(mk_point(1, 32'h0, 32'hFFFFFFFF, 32'h7FFFFFFF));
    send_point(mk_point(0, 32'h80000000, 32'h0, 32'h1));
    wait_drained();

    // Random phases over a spread of settings
    random_phase(24'h000001, 32'h0, 90, 0);
    random_phase(24'hFFFFFF, 32'hFFFFFFFF, 90, 1);
    random_phase(24'($urandom), $urandom, 90, 0);
    random_phase(24'h0, $urandom, 60, 0);
    random_phase(24'h010000, SEED_RESET, 90, 0);
    random_phase(24'($urandom_range(1, 24'h0FFFFF)), $urandom, 90, 0);

    end_check <= 1;
    @(posedge clk);
    @(negedge clk);

    $display("covered %0d points over %0d register settings (%0d writes),",
             points_checked, phases, cfg_writes);
    $display("including reseeds, pass-through, saturation and a long output stall");
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
